### hw/rtl/pcbn_pkg.sv
package pcbn_pkg;

   localparam int DEF_MAX_DETECTIONS = 64;
   localparam int DEF_MAX_CLASSES    = 128;

   localparam int CLS_W   = 7;
   localparam int SCORE_W = 16;
   localparam int POS_W   = 20;
   localparam int SIZE_W  = 19;
   localparam int THR_W   = 16;
   localparam int NCLS_W  = 8;

   // beat payload: class, score, x, y, width, height, zero fill to bytes
   localparam int ITEM_W  = CLS_W + SCORE_W + 2 * POS_W + 2 * SIZE_W;
   localparam int TDATA_W = ((ITEM_W + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [THR_W-1:0]  THR_RESET  = 16'd29491;
   localparam logic [NCLS_W-1:0] NCLS_RESET = 8'd80;

   // register index, taken from paddr bit 2
   localparam logic REG_IOU_THR   = 1'b0;
   localparam logic REG_NUM_CLASS = 1'b1;

   // doubled-scale edge, one spare bit for the span
   localparam int EDGE_W  = POS_W + 3;
   localparam int SPAN_W  = POS_W + 2;
   localparam int INTER_W = 2 * SPAN_W;
   localparam int AREA_W  = 2 * SIZE_W;
   localparam int UNION_W = AREA_W + 4;
   localparam int PROD_W  = UNION_W + THR_W;
   localparam int LHS_W   = INTER_W + THR_W;

endpackage

### hw/rtl/per_class_box_nms.sv
// channel | dir | tdata (low bit up)                            | tuser | tlast
// req     | in  | class_id, score, center_x, center_y, w, h     | -     | last_in
// rsp     | out | kept_class, kept_score, kept_x, kept_y, w, h  | -     | last_out
// csr     | in  | apb, 0x0 iou_threshold, 0x4 num_classes       | -     | -
//
// a beat without tlast is stored (beats past MAX_DETECTIONS are dropped); req_tready then stays high
// a tlast beat starts frame processing (N entries): a pass over all N sets alive flags,
// then per kept box a search pass, a hand-off and load of it, and per entry a check
// plus an iou test per same-class candidate; a last search that finds nothing ends it
// reset (synchronous) empties the frame and restores register defaults
// the search end waits while a stalled rsp beat keeps the previous kept box back
module per_class_box_nms #(
   parameter int MAX_DETECTIONS = pcbn_pkg::DEF_MAX_DETECTIONS,
   parameter int MAX_CLASSES    = pcbn_pkg::DEF_MAX_CLASSES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // class_id, score, center_x, center_y, box_width, box_height, zero fill
   input  logic [pcbn_pkg::TDATA_W-1:0]    req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // kept_class, kept_score, kept_x, kept_y, kept_width, kept_height, zero fill
   output logic [pcbn_pkg::TDATA_W-1:0]    rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pcbn_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pcbn_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pcbn_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   import pcbn_pkg::*;

   localparam int IW = $clog2(MAX_DETECTIONS);
   localparam int CW = $clog2(MAX_DETECTIONS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT_A, ST_INIT_B, ST_SEL_A, ST_SEL_B, ST_SEL_DONE,
      ST_LOAD_A, ST_LOAD_B, ST_AREA, ST_SUP_A, ST_SUP_B, ST_EDGE,
      ST_MUL, ST_UNION, ST_CMP
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [THR_W-1:0]  thr_ff;
   logic [NCLS_W-1:0] ncls_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THR_RESET;
         ncls_ff <= NCLS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            REG_IOU_THR:   thr_ff  <= csr_pwdata[THR_W-1:0];
            REG_NUM_CLASS: ncls_ff <= csr_pwdata[NCLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_IOU_THR:   csr_prdata = CSR_DATA_W'(thr_ff);
         REG_NUM_CLASS: csr_prdata = CSR_DATA_W'(ncls_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // box stores, one shared read address, registered read data
   logic [CLS_W-1:0]      cls_mem [MAX_DETECTIONS];
   logic [SCORE_W-1:0]    score_mem [MAX_DETECTIONS];
   logic [2*POS_W-1:0]    ctr_mem [MAX_DETECTIONS];
   logic [2*SIZE_W-1:0]   size_mem [MAX_DETECTIONS];

   logic [CLS_W-1:0]      cls_q;
   logic [SCORE_W-1:0]    score_q;
   logic [2*POS_W-1:0]    ctr_q;
   logic [2*SIZE_W-1:0]   size_q;

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         scan_ff;
   logic [IW-1:0]         best_ff;
   logic [IW-1:0]         rd_idx;
   logic [MAX_DETECTIONS-1:0] alive_ff;

   logic req_beat, wr_en;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign wr_en      = req_beat && (count_ff != CW'(MAX_DETECTIONS));

   always_comb begin
      case (state_ff)
         ST_LOAD_A, ST_LOAD_B: rd_idx = best_ff;
         default:              rd_idx = scan_ff[IW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cls_mem[count_ff[IW-1:0]]   <= req_tdata[CLS_W-1:0];
         score_mem[count_ff[IW-1:0]] <= req_tdata[CLS_W +: SCORE_W];
         ctr_mem[count_ff[IW-1:0]]   <= req_tdata[CLS_W+SCORE_W +: 2*POS_W];
         size_mem[count_ff[IW-1:0]]  <= req_tdata[CLS_W+SCORE_W+2*POS_W +: 2*SIZE_W];
      end
      cls_q   <= cls_mem[rd_idx];
      score_q <= score_mem[rd_idx];
      ctr_q   <= ctr_mem[rd_idx];
      size_q  <= size_mem[rd_idx];
   end

   // search results and the pending kept box
   logic                  found_ff;
   logic [CLS_W-1:0]      bcls_ff;
   logic [SCORE_W-1:0]    bscore_ff;
   logic                  pend_ff;
   logic [CLS_W-1:0]      pcls_ff;
   logic [SCORE_W-1:0]    pscore_ff;
   logic [2*POS_W-1:0]    pctr_ff;
   logic [2*SIZE_W-1:0]   psize_ff;
   logic [AREA_W-1:0]     parea_ff;

   // iou datapath registers
   logic [SPAN_W-1:0]     dx_ff, dy_ff;
   logic                  empty_ff;
   logic [INTER_W-1:0]    inter_ff;
   logic [AREA_W-1:0]     carea_ff;
   logic [UNION_W-1:0]    union_ff;

   logic                  rsp_valid_ff, rsp_last_ff;
   logic [TDATA_W-1:0]    rsp_data_ff;
   logic                  out_free;
   logic                  rsp_load;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == ST_SEL_DONE) && pend_ff && out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   logic scan_end;
   assign scan_end = (scan_ff == count_ff - CW'(1));

   logic in_class;
   assign in_class = ({1'b0, cls_q} < {1'b0, ncls_ff}) &&
                     ({{(32-CLS_W){1'b0}}, cls_q} < 32'(MAX_CLASSES));

   logic better;
   assign better = alive_ff[scan_ff[IW-1:0]] &&
                   (!found_ff || (cls_q < bcls_ff) ||
                    ((cls_q == bcls_ff) && (score_q > bscore_ff)));

   // edges at doubled scale: 2*center -/+ size
   logic signed [EDGE_W-1:0] al, ar, at, ad, bl, br, bt, bd;
   logic signed [EDGE_W-1:0] l_e, r_e, t_e, d_e, sx, sy;

   always_comb begin
      al = $signed({{2{pctr_ff[POS_W-1]}}, pctr_ff[POS_W-1:0], 1'b0})
         - $signed({4'b0, psize_ff[SIZE_W-1:0]});
      ar = $signed({{2{pctr_ff[POS_W-1]}}, pctr_ff[POS_W-1:0], 1'b0})
         + $signed({4'b0, psize_ff[SIZE_W-1:0]});
      at = $signed({{2{pctr_ff[2*POS_W-1]}}, pctr_ff[2*POS_W-1:POS_W], 1'b0})
         - $signed({4'b0, psize_ff[2*SIZE_W-1:SIZE_W]});
      ad = $signed({{2{pctr_ff[2*POS_W-1]}}, pctr_ff[2*POS_W-1:POS_W], 1'b0})
         + $signed({4'b0, psize_ff[2*SIZE_W-1:SIZE_W]});
      bl = $signed({{2{ctr_q[POS_W-1]}}, ctr_q[POS_W-1:0], 1'b0})
         - $signed({4'b0, size_q[SIZE_W-1:0]});
      br = $signed({{2{ctr_q[POS_W-1]}}, ctr_q[POS_W-1:0], 1'b0})
         + $signed({4'b0, size_q[SIZE_W-1:0]});
      bt = $signed({{2{ctr_q[2*POS_W-1]}}, ctr_q[2*POS_W-1:POS_W], 1'b0})
         - $signed({4'b0, size_q[2*SIZE_W-1:SIZE_W]});
      bd = $signed({{2{ctr_q[2*POS_W-1]}}, ctr_q[2*POS_W-1:POS_W], 1'b0})
         + $signed({4'b0, size_q[2*SIZE_W-1:SIZE_W]});
      l_e = (al > bl) ? al : bl;
      r_e = (ar < br) ? ar : br;
      t_e = (at > bt) ? at : bt;
      d_e = (ad < bd) ? ad : bd;
      sx  = r_e - l_e;
      sy  = d_e - t_e;
   end

   logic [PROD_W-1:0] prod;
   logic              kill;
   assign prod = PROD_W'(thr_ff) * PROD_W'(union_ff);
   assign kill = !empty_ff && ({inter_ff, {THR_W{1'b0}}} > LHS_W'(prod));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_beat && req_tlast) state_in = ST_INIT_A;
         ST_INIT_A:   state_in = ST_INIT_B;
         ST_INIT_B:   state_in = scan_end ? ST_SEL_A : ST_INIT_A;
         ST_SEL_A:    state_in = ST_SEL_B;
         ST_SEL_B:    state_in = scan_end ? ST_SEL_DONE : ST_SEL_A;
         ST_SEL_DONE: if (!pend_ff || out_free)
                         state_in = found_ff ? ST_LOAD_A : ST_IDLE;
         ST_LOAD_A:   state_in = ST_LOAD_B;
         ST_LOAD_B:   state_in = ST_AREA;
         ST_AREA:     state_in = ST_SUP_A;
         ST_SUP_A:    state_in = ST_SUP_B;
         ST_SUP_B:    if (alive_ff[scan_ff[IW-1:0]] && (cls_q == pcls_ff))
                         state_in = ST_EDGE;
                      else
                         state_in = scan_end ? ST_SEL_A : ST_SUP_A;
         ST_EDGE:     state_in = ST_MUL;
         ST_MUL:      state_in = ST_UNION;
         ST_UNION:    state_in = ST_CMP;
         ST_CMP:      state_in = scan_end ? ST_SEL_A : ST_SUP_A;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         alive_ff     <= '0;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (wr_en) count_ff <= count_ff + CW'(1);
               scan_ff <= '0;
            end
            ST_INIT_B: begin
               alive_ff[scan_ff[IW-1:0]] <= in_class;
               scan_ff  <= scan_end ? '0 : scan_ff + CW'(1);
               found_ff <= 1'b0;
            end
            ST_SEL_B: begin
               if (better) begin
                  found_ff  <= 1'b1;
                  best_ff   <= scan_ff[IW-1:0];
                  bcls_ff   <= cls_q;
                  bscore_ff <= score_q;
               end
               if (!scan_end) scan_ff <= scan_ff + CW'(1);
            end
            ST_SEL_DONE: begin
               if (!pend_ff || out_free) begin
                  // previous kept box goes out; it is the frame's final one
                  // when the search found nothing more
                  if (pend_ff) begin
                     rsp_last_ff  <= !found_ff;
                     rsp_data_ff  <= TDATA_W'({psize_ff, pctr_ff, pscore_ff, pcls_ff});
                     pend_ff      <= 1'b0;
                  end
                  if (found_ff) begin
                     alive_ff[best_ff] <= 1'b0;
                  end else begin
                     count_ff <= '0;
                     alive_ff <= '0;
                  end
               end
            end
            ST_LOAD_B: begin
               pend_ff   <= 1'b1;
               pcls_ff   <= cls_q;
               pscore_ff <= score_q;
               pctr_ff   <= ctr_q;
               psize_ff  <= size_q;
            end
            ST_AREA: begin
               parea_ff <= AREA_W'(psize_ff[SIZE_W-1:0]) *
                           AREA_W'(psize_ff[2*SIZE_W-1:SIZE_W]);
               scan_ff  <= '0;
               found_ff <= 1'b0;
            end
            ST_SUP_B: begin
               if (!(alive_ff[scan_ff[IW-1:0]] && (cls_q == pcls_ff)))
                  scan_ff <= scan_end ? '0 : scan_ff + CW'(1);
            end
            ST_EDGE: begin
               empty_ff <= (l_e > r_e) || (t_e > d_e);
               dx_ff    <= sx[SPAN_W-1:0];
               dy_ff    <= sy[SPAN_W-1:0];
            end
            ST_MUL: begin
               inter_ff <= INTER_W'(dx_ff) * INTER_W'(dy_ff);
               carea_ff <= AREA_W'(size_q[SIZE_W-1:0]) *
                           AREA_W'(size_q[2*SIZE_W-1:SIZE_W]);
            end
            ST_UNION: begin
               union_ff <= {2'b0, parea_ff, 2'b0} + {2'b0, carea_ff, 2'b0}
                         - UNION_W'(inter_ff);
            end
            ST_CMP: begin
               if (kill) alive_ff[scan_ff[IW-1:0]] <= 1'b0;
               scan_ff <= scan_end ? '0 : scan_ff + CW'(1);
            end
            default: ;
         endcase
      end
   end

endmodule

### hw/rtl/pcbn_checker.sv
module pcbn_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pcbn_pkg::TDATA_W-1:0]    rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            csr_pready
);

   import pcbn_pkg::*;

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // the frame end closes the input: no req beat is taken right after it
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("req taken right after frame end");

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("rsp beat after reset");

   // config port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind per_class_box_nms pcbn_checker u_pcbn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);
